// File: hw/rtl/lgs_pkg.sv
// Shared constants, codes and types for the life grid generation step block.
// No dependencies; all files of the block but lgs_req_if refer to this package.
`timescale 1ns / 1ps

package lgs_pkg;

   localparam int ROW_W             = 12;
   localparam int GRID_W_W          = 11;
   localparam int GRID_H_W          = 12;
   localparam int CSR_DATA_W        = 12;
   localparam int CSR_IDX_W         = 2;
   localparam int WINDOW_BITS       = 9;
   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int RESET_GRID_SIZE   = 64;
   localparam int MIN_GRID_SIZE     = 3;
   localparam int FIRST_EMIT_POS    = 2;
   localparam int NEIGHBORS_KEEP    = 2;
   localparam int NEIGHBORS_BIRTH   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH  = 2'd0,
      REG_GRID_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic             restart;
      logic [ROW_W-1:0] last_row;
   } geom_ctrl_type;

endpackage

// File: hw/rtl/lgs_req_if.sv
// Input channel of the life grid generation step block: one cell per word.
// Depends on nothing.
`timescale 1ns / 1ps

interface lgs_req_if;
   logic valid;
   logic ready;
   logic cell_alive;

   modport source (output valid, output cell_alive, input ready);
   modport sink (input valid, input cell_alive, output ready);
endinterface

// File: hw/rtl/lgs_rsp_if.sv
// Result channel of the life grid generation step block.
// Depends on lgs_pkg for the row index width.
`timescale 1ns / 1ps

interface lgs_rsp_if #(
   parameter int COL_W = $clog2(lgs_pkg::DEFAULT_MAX_WIDTH)
);
   logic                     valid;
   logic                     ready;
   logic [lgs_pkg::ROW_W-1:0] out_row;
   logic [COL_W-1:0]         out_col;
   logic                     next_alive;
   logic                     last_of_grid;

   modport source (output valid, output out_row, output out_col, output next_alive,
                   output last_of_grid, input ready);
   modport sink (input valid, input out_row, input out_col, input next_alive,
                 input last_of_grid, output ready);
endinterface

// File: hw/rtl/lgs_csr_if.sv
// Configuration write channel of the life grid generation step block.
// Depends on lgs_pkg for the index and data widths.
`timescale 1ns / 1ps

interface lgs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lgs_pkg::CSR_IDX_W-1:0]  index;
   logic [lgs_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: hw/rtl/life_grid_generation_step.sv
// Life grid generation step: B3/S23 over a raster cell stream.
// Depends on lgs_pkg, the channel interfaces, lgs_geometry, lgs_line_buf
// and lgs_window.
//
// Cells of one generation enter on req, one word per cell in row-major
// order, border included. For every cell at row r >= 2 and column c >= 2 one
// word leaves on rsp with the next state of interior cell (r-1, c-1);
// last_of_grid marks the final interior cell. Other inputs give no word.
// The csr channel sets grid_width (index 0) and grid_height (index 1);
// either write restarts the generation at row 0, column 0. It is always
// ready and must only be used while the block is idle.
// A cell passes from req through the working stage and the output register.
// One cell is accepted every cycle while rsp does not stall; the line buffer
// is read as a cell is accepted and written back as it leaves the working
// stage, so both ports of the memory stay busy. When rsp stalls, one word
// waits in the output register and one more in the working stage, after
// which req ready drops. Reset restores a 64 by 64 grid, its width capped at
// MAX_WIDTH, and the start position; the line buffer needs no clearing since
// every value that reaches a result was written earlier in the same pass.
`timescale 1ns / 1ps

module life_grid_generation_step #(
   parameter int MAX_WIDTH = lgs_pkg::DEFAULT_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic     clock,
   input  logic     reset,
   lgs_req_if.sink  req,
   lgs_rsp_if.source rsp,
   lgs_csr_if.sink  csr
);
   import lgs_pkg::*;

   geom_ctrl_type    geom;
   logic [COL_W-1:0] last_col;

   logic             accept, s1_adv;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_cell_ff;
   logic             s1_emit_ff;
   logic             s1_last_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [1:0]       above;
   logic             next_alive;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0] rsp_row_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic             rsp_alive_ff;
   logic             rsp_last_ff;

   lgs_geometry #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_geometry (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .last_col (last_col),
      .geom     (geom)
   );

   lgs_line_buf #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (above),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({above[0], s1_cell_ff})
   );

   lgs_window u_window (
      .clock       (clock),
      .reset       (reset),
      .shift_en    (s1_adv),
      .cell_cur    (s1_cell_ff),
      .cell_one_up (above[0]),
      .cell_two_up (above[1]),
      .next_alive  (next_alive)
   );

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign accept    = req.valid && req.ready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (geom.restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == geom.last_row) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      s1_valid_in = accept || (s1_valid_ff && !s1_adv);
      if (s1_adv) begin
         rsp_valid_in = s1_emit_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff <= req.cell_alive;
         s1_row_ff  <= row_ff;
         s1_col_ff  <= col_ff;
         s1_emit_ff <= (row_ff >= ROW_W'(FIRST_EMIT_POS)) &&
                       (col_ff >= COL_W'(FIRST_EMIT_POS));
         s1_last_ff <= (row_ff == geom.last_row) && (col_ff == last_col);
      end
      if (s1_adv) begin
         rsp_row_ff   <= s1_row_ff - ROW_W'(1);
         rsp_col_ff   <= s1_col_ff - COL_W'(1);
         rsp_alive_ff <= next_alive;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_row      = rsp_row_ff;
   assign rsp.out_col      = rsp_col_ff;
   assign rsp.next_alive   = rsp_alive_ff;
   assign rsp.last_of_grid = rsp_last_ff;

   a_ready_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp.ready))
      else $error("req ready dropped while the pipeline had room");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col)
      else $error("column counter ran past the last column");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= geom.last_row)
      else $error("row counter ran past the last row");

   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff != '0) && (rsp_col_ff != '0))
      else $error("a border cell was produced");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |->
         (rsp_row_ff == geom.last_row - ROW_W'(1)) &&
         (rsp_col_ff == last_col - COL_W'(1)))
      else $error("last_of_grid set away from the final interior cell");

endmodule

// File: hw/rtl/lgs_geometry.sv
// Geometry registers: saturates grid width and height on write and keeps the
// last column and last row indexes. Depends on lgs_pkg and lgs_csr_if.
`timescale 1ns / 1ps

module lgs_geometry #(
   parameter int MAX_WIDTH = lgs_pkg::DEFAULT_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   lgs_csr_if.sink               csr,
   output logic [COL_W-1:0]      last_col,
   output lgs_pkg::geom_ctrl_type geom
);
   import lgs_pkg::*;

   localparam int MAXW_BITS = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W     = (GRID_W_W > MAXW_BITS) ? GRID_W_W : MAXW_BITS;
   localparam int RESET_W   = (RESET_GRID_SIZE < MAX_WIDTH) ? RESET_GRID_SIZE : MAX_WIDTH;

   logic [COL_W-1:0]    last_col_ff, last_col_in;
   logic [ROW_W-1:0]    last_row_ff, last_row_in;
   logic                wr_width, wr_height;
   logic [CMP_W-1:0]    width_ext, width_sat;
   logic [GRID_H_W-1:0] height_raw, height_sat;

   assign csr.ready = 1'b1;
   assign wr_width  = csr.valid && (csr.index == REG_GRID_WIDTH);
   assign wr_height = csr.valid && (csr.index == REG_GRID_HEIGHT);

   always_comb begin
      width_ext  = CMP_W'(csr.wdata[GRID_W_W-1:0]);
      height_raw = csr.wdata[GRID_H_W-1:0];
      if (width_ext < CMP_W'(MIN_GRID_SIZE)) begin
         width_sat = CMP_W'(MIN_GRID_SIZE);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_sat = CMP_W'(MAX_WIDTH);
      end else begin
         width_sat = width_ext;
      end
      if (height_raw < GRID_H_W'(MIN_GRID_SIZE)) begin
         height_sat = GRID_H_W'(MIN_GRID_SIZE);
      end else begin
         height_sat = height_raw;
      end
      last_col_in = wr_width ? COL_W'(width_sat - CMP_W'(1)) : last_col_ff;
      last_row_in = wr_height ? ROW_W'(height_sat - GRID_H_W'(1)) : last_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= COL_W'(RESET_W - 1);
         last_row_ff <= ROW_W'(RESET_GRID_SIZE - 1);
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
      end
   end

   assign last_col      = last_col_ff;
   assign geom.last_row = last_row_ff;
   assign geom.restart  = wr_width || wr_height;

endmodule

// File: hw/rtl/lgs_line_buf.sv
// Line buffer memory holding, per column, the cells one and two rows above.
// Synchronous read, one write port. Depends on lgs_pkg.
`timescale 1ns / 1ps

module lgs_line_buf #(
   parameter int MAX_WIDTH = lgs_pkg::DEFAULT_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output logic [1:0]       rd_data,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [1:0]       wr_data
);
   import lgs_pkg::*;

   // Bit 1 is the cell two rows above, bit 0 the cell one row above.
   logic [1:0] mem [MAX_WIDTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lgs_window.sv
// Sliding 3x3 window and the B3/S23 rule applied to the updated window.
// Depends on lgs_pkg.
`timescale 1ns / 1ps

module lgs_window (
   input  logic clock,
   input  logic reset,
   input  logic shift_en,
   input  logic cell_cur,
   input  logic cell_one_up,
   input  logic cell_two_up,
   output logic next_alive
);
   import lgs_pkg::*;

   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic [3:0]             total;
   logic                   center;

   always_comb begin
      total = 4'd0;
      window_in = {cell_cur, window_ff[8:7], cell_one_up, window_ff[5:4],
                   cell_two_up, window_ff[2:1]};
      for (int i = 0; i < WINDOW_BITS; i++) begin
         total = total + 4'(window_in[i]);
      end
      center = window_in[4];
      // The total includes the center, so survival with two neighbors
      // shows up as a total of three with the center live.
      next_alive = (total == 4'(NEIGHBORS_BIRTH)) ||
                   (center && (total == 4'(NEIGHBORS_KEEP + 1))) ||
                   (center && (total == 4'(NEIGHBORS_BIRTH + 1)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (shift_en) begin
         window_ff <= window_in;
      end
   end

endmodule
